// ----- hw/rtl/gbt_pkg.sv -----
// Package for the graph traversal block: sizes, request/status/mark codes,
// controller states and the neighbour RAM request struct.
// No dependencies.
package gbt_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_DEGREE   = 16;

    localparam int VIDX_W  = 4;   // vertex index field
    localparam int KEY_W   = 8;
    localparam int VCNT_W  = 5;   // vertex_count register
    localparam int PTR_W   = $clog2(MAX_VERTICES + 1);
    localparam int CNT_W   = $clog2(MAX_DEGREE + 1);
    localparam int DEG_IW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int NBR_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int NBR_AW  = $clog2(NBR_DEPTH);

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(16);

    typedef enum logic [1:0] {
        REQ_SET_KEY  = 2'd0,
        REQ_ADD_EDGE = 2'd1,
        REQ_BFS      = 2'd2,
        REQ_DFS      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MARK_NONE    = 2'd0,
        MARK_PENDING = 2'd1,
        MARK_DONE    = 2'd2
    } mark_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_WR_A,
        ST_WR_B,
        ST_FINISH,
        ST_WALK_INIT,
        ST_POP,
        ST_LOAD,
        ST_SCAN,
        ST_VISIT
    } fsm_state_t;

    typedef struct packed {
        logic              we;
        logic [NBR_AW-1:0] waddr;
        logic [VIDX_W-1:0] wdata;
        logic              re;
        logic [NBR_AW-1:0] raddr;
    } nbr_ram_req_t;

    function automatic logic [NBR_AW-1:0] nbr_addr(input logic [VIDX_W-1:0] v,
                                                   input logic [DEG_IW-1:0] i);
        return NBR_AW'(int'(v) * MAX_DEGREE + int'(i));
    endfunction

endpackage

// ----- hw/rtl/gbt_nbr_ram.sv -----
// Neighbour list store: single write port, single read port, registered read.
// Depends on gbt_pkg.
module gbt_nbr_ram (
    input  logic                 aclk,
    input  gbt_pkg::nbr_ram_req_t req,
    output logic [gbt_pkg::VIDX_W-1:0] rdata
);
    import gbt_pkg::*;

    logic [VIDX_W-1:0] mem [NBR_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// ----- hw/rtl/graph_bfs_dfs_traversal_top.sv -----
// Graph traversal block top level: request decode, controller, per-vertex state.
// Depends on gbt_pkg and gbt_nbr_ram.
//
// Channel | Direction | Handshake         | Payload
// --------+-----------+-------------------+----------------------------------------------
// s_      | in        | s_valid/s_ready   | req_type, vertex_a, vertex_b, key_value
// m_      | out       | m_valid/m_ready   | visited_index, visited_key, last_flag, status_code
// cfg_    | in        | cfg_wr_en         | cfg_wr_data (vertex_count)
//
// One request is worked at a time; s_ready is high only while the controller is idle.
// A walk reads each reached vertex's neighbour list from the RAM one entry a cycle.
// Results sit in an output register, so a stalled m_ready holds the controller only when
// it has the next result to place. Reset gives vertex_count 16, empty lists and zero keys.
module graph_bfs_dfs_traversal_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [gbt_pkg::VIDX_W-1:0]   s_vertex_a,
    input  logic [gbt_pkg::VIDX_W-1:0]   s_vertex_b,
    input  logic [gbt_pkg::KEY_W-1:0]    s_key_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gbt_pkg::VIDX_W-1:0]   m_visited_index,
    output logic [gbt_pkg::KEY_W-1:0]    m_visited_key,
    output logic                         m_last_flag,
    output logic [1:0]                   m_status_code,
    input  logic                         cfg_wr_en,
    input  logic [gbt_pkg::VCNT_W-1:0]   cfg_wr_data
);
    import gbt_pkg::*;

    // Control and request registers
    fsm_state_t        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [VIDX_W-1:0] a_reg, a_next;
    logic [VIDX_W-1:0] b_reg, b_next;
    logic [KEY_W-1:0]  keyin_reg, keyin_next;
    status_t           stat_reg, stat_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [VCNT_W-1:0] vcount_reg;

    // Walk registers
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [VIDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  deg_reg, deg_next;
    logic [KEY_W-1:0]  curkey_reg, curkey_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rd_pend_reg, rd_pend_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [VIDX_W-1:0] out_idx_reg, out_idx_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic              out_last_reg, out_last_next;
    status_t           out_stat_reg, out_stat_next;

    // Per-vertex state in flops
    logic [CNT_W-1:0]  counts_reg [MAX_VERTICES];
    logic [KEY_W-1:0]  keys_reg   [MAX_VERTICES];
    mark_t             marks_reg  [MAX_VERTICES];
    logic [VIDX_W-1:0] wl_reg     [MAX_VERTICES];

    // Write strobes for the arrays
    logic              key_we;
    logic              cnt_inc;
    logic [VIDX_W-1:0] cnt_idx;
    logic              mark_clear;
    logic              mark_we;
    logic [VIDX_W-1:0] mark_idx;
    mark_t             mark_val;
    logic              wl_we;
    logic [VIDX_W-1:0] wl_idx;
    logic [VIDX_W-1:0] wl_val;

    nbr_ram_req_t      ram_req;
    logic [VIDX_W-1:0] ram_rdata;

    logic [PTR_W-1:0]  n_live;
    logic              can_emit;
    logic              a_bad, b_bad;
    logic              list_full;
    logic [PTR_W-1:0]  tail_dec;
    logic              scan_issue;
    logic              push_ok;

    gbt_nbr_ram u_nbr_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Effective vertex count: zero acts as one, clamp at the table size
    always_comb begin
        if (vcount_reg == '0) begin
            n_live = PTR_W'(1);
        end else if (int'(vcount_reg) > MAX_VERTICES) begin
            n_live = PTR_W'(MAX_VERTICES);
        end else begin
            n_live = PTR_W'(vcount_reg);
        end
    end

    assign can_emit  = !out_valid_reg || m_ready;
    assign a_bad     = int'(a_reg) >= int'(n_live);
    assign b_bad     = int'(b_reg) >= int'(n_live);
    // self-loop needs two free slots in one list
    assign list_full = (a_reg == b_reg) ? (int'(cnt_a_reg) + 2 > MAX_DEGREE)
                     : ((int'(cnt_a_reg) >= MAX_DEGREE) ||
                        (int'(counts_reg[b_reg]) >= MAX_DEGREE));
    assign tail_dec  = tail_reg - PTR_W'(1);
    assign scan_issue = int'(idx_reg) < int'(deg_reg);
    assign push_ok   = (int'(ram_rdata) < int'(n_live)) &&
                       (marks_reg[ram_rdata] == MARK_NONE) &&
                       (int'(tail_reg) < MAX_VERTICES);

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        keyin_next     = keyin_reg;
        stat_next      = stat_reg;
        cnt_a_next     = cnt_a_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        deg_next       = deg_reg;
        curkey_next    = curkey_reg;
        idx_next       = idx_reg;
        rd_pend_next   = rd_pend_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_idx_next   = out_idx_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;
        out_stat_next  = out_stat_reg;
        key_we         = 1'b0;
        cnt_inc        = 1'b0;
        cnt_idx        = a_reg;
        mark_clear     = 1'b0;
        mark_we        = 1'b0;
        mark_idx       = cur_reg;
        mark_val       = MARK_DONE;
        wl_we          = 1'b0;
        wl_idx         = tail_reg[VIDX_W-1:0];
        wl_val         = ram_rdata;
        ram_req        = '0;
        s_ready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = req_t'(s_req_type);
                    a_next     = s_vertex_a;
                    b_next     = s_vertex_b;
                    keyin_next = s_key_value;
                    case (req_t'(s_req_type))
                        REQ_SET_KEY:  state_next = ST_KEY;
                        REQ_ADD_EDGE: state_next = ST_EDGE_A;
                        default:      state_next = ST_WALK_INIT;
                    endcase
                end
            end
            ST_KEY: begin
                if (a_bad) begin
                    stat_next = STAT_RANGE;
                end else begin
                    key_we    = 1'b1;
                    stat_next = STAT_OK;
                end
                state_next = ST_FINISH;
            end
            ST_EDGE_A: begin
                cnt_a_next = counts_reg[a_reg];
                state_next = ST_EDGE_B;
            end
            ST_EDGE_B: begin
                if (a_bad || b_bad) begin
                    stat_next  = STAT_RANGE;
                    state_next = ST_FINISH;
                end else if (list_full) begin
                    stat_next  = STAT_FULL;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_WR_A;
                end
            end
            ST_WR_A: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = nbr_addr(a_reg, cnt_a_reg[DEG_IW-1:0]);
                ram_req.wdata = b_reg;
                cnt_inc       = 1'b1;
                cnt_idx       = a_reg;
                state_next    = ST_WR_B;
            end
            ST_WR_B: begin
                // count of b re-read here, so a self-loop lands in the next slot
                ram_req.we    = 1'b1;
                ram_req.waddr = nbr_addr(b_reg, counts_reg[b_reg][DEG_IW-1:0]);
                ram_req.wdata = a_reg;
                cnt_inc       = 1'b1;
                cnt_idx       = b_reg;
                stat_next     = STAT_OK;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (can_emit) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    out_key_next   = '0;
                    out_last_next  = 1'b1;
                    out_stat_next  = stat_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_WALK_INIT: begin
                mark_clear = 1'b1;
                wl_we      = 1'b1;
                wl_idx     = '0;
                wl_val     = '0;
                head_next  = '0;
                tail_next  = PTR_W'(1);
                state_next = ST_POP;
            end
            ST_POP: begin
                if (req_reg == REQ_DFS) begin
                    cur_next  = wl_reg[tail_dec[VIDX_W-1:0]];
                    tail_next = tail_dec;
                end else begin
                    cur_next  = wl_reg[head_reg[VIDX_W-1:0]];
                    head_next = head_reg + PTR_W'(1);
                end
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                deg_next     = counts_reg[cur_reg];
                curkey_next  = keys_reg[cur_reg];
                idx_next     = '0;
                rd_pend_next = 1'b0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                rd_pend_next = scan_issue;
                if (scan_issue) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = nbr_addr(cur_reg, idx_reg[DEG_IW-1:0]);
                    idx_next      = idx_reg + CNT_W'(1);
                end
                if (rd_pend_reg) begin
                    if (push_ok) begin
                        mark_we   = 1'b1;
                        mark_idx  = ram_rdata;
                        mark_val  = MARK_PENDING;
                        wl_we     = 1'b1;
                        wl_idx    = tail_reg[VIDX_W-1:0];
                        wl_val    = ram_rdata;
                        tail_next = tail_reg + PTR_W'(1);
                    end
                end else if (!scan_issue) begin
                    mark_we    = 1'b1;
                    mark_idx   = cur_reg;
                    mark_val   = MARK_DONE;
                    state_next = ST_VISIT;
                end
            end
            ST_VISIT: begin
                if (can_emit) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = cur_reg;
                    out_key_next   = curkey_reg;
                    out_last_next  = (tail_reg == head_reg);
                    out_stat_next  = STAT_OK;
                    state_next     = (tail_reg == head_reg) ? ST_IDLE : ST_POP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            vcount_reg    <= VCOUNT_RESET;
        end else begin
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        keyin_reg    <= keyin_next;
        stat_reg     <= stat_next;
        cnt_a_reg    <= cnt_a_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        cur_reg      <= cur_next;
        deg_reg      <= deg_next;
        curkey_reg   <= curkey_next;
        idx_reg      <= idx_next;
        out_idx_reg  <= out_idx_next;
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
        out_stat_reg <= out_stat_next;
    end

    // Per-vertex tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < MAX_VERTICES; v++) begin
                counts_reg[v] <= '0;
                keys_reg[v]   <= '0;
                marks_reg[v]  <= MARK_NONE;
            end
        end else begin
            if (key_we) begin
                keys_reg[a_reg] <= keyin_reg;
            end
            if (cnt_inc) begin
                counts_reg[cnt_idx] <= counts_reg[cnt_idx] + CNT_W'(1);
            end
            if (mark_clear) begin
                // vertex 0 starts the walk already queued
                for (int v = 0; v < MAX_VERTICES; v++) begin
                    marks_reg[v] <= (v == 0) ? MARK_PENDING : MARK_NONE;
                end
            end else if (mark_we) begin
                marks_reg[mark_idx] <= mark_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wl_we) begin
            wl_reg[wl_idx] <= wl_val;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_visited_index = out_idx_reg;
    assign m_visited_key   = out_key_reg;
    assign m_last_flag     = out_last_reg;
    assign m_status_code   = out_stat_reg;

`ifndef SYNTH
    a_tail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (int'(tail_reg) <= MAX_VERTICES))
        else $error("work list overran its depth");

    a_head_le_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_VISIT) |-> (head_reg <= tail_reg))
        else $error("work list head passed tail");

    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_stat_reg != STAT_OK) |-> out_last_reg)
        else $error("error result not flagged last");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_A) |=> (int'(counts_reg[a_reg]) <= MAX_DEGREE))
        else $error("neighbour count beyond list size");

    a_pend_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_SCAN))
        else $error("neighbour read pending outside scan");

    a_no_emit_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg)
        else $error("result dropped while stalled");
`endif

endmodule

// ----- test/graph_bfs_dfs_traversal_top_test.sv -----
// Self-checking bench for graph_bfs_dfs_traversal_top: directed table, then random phases,
// each result compared against a cycle-free model of the graph and its two walks.
// Depends on gbt_pkg and the graph_bfs_dfs_traversal_top RTL.
module graph_bfs_dfs_traversal_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbt_pkg::*;

    // One result transfer as the bench expects it
    typedef struct {
        logic [VIDX_W-1:0] vidx;
        logic [KEY_W-1:0]  vkey;
        logic              last;
        status_t           status;
    } visit_res_t;

    // One row of the directed table. cfg asks for a vertex_count write (with the block
    // drained first); typed rows carry their single result, the rest go to the model.
    typedef struct {
        bit                cfg;
        logic [VCNT_W-1:0] cfg_val;
        req_t              rq;
        logic [VIDX_W-1:0] va;
        logic [VIDX_W-1:0] vb;
        logic [KEY_W-1:0]  kv;
        bit                typed;
        logic [VIDX_W-1:0] t_idx;
        logic [KEY_W-1:0]  t_key;
        status_t           t_stat;
    } stim_row_t;

    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 32;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int HOLD_AFTER    = 60;    // results seen before the hold-off starts
    localparam int GAP_CAP       = 20;
    localparam int SETTLE_LIMIT  = 50000;

    // DUT ports
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [1:0]          s_req_type  = '0;
    logic [VIDX_W-1:0]   s_vertex_a  = '0;
    logic [VIDX_W-1:0]   s_vertex_b  = '0;
    logic [KEY_W-1:0]    s_key_value = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [VIDX_W-1:0]   m_visited_index;
    logic [KEY_W-1:0]    m_visited_key;
    logic                m_last_flag;
    logic [1:0]          m_status_code;
    logic                cfg_wr_en   = 1'b0;
    logic [VCNT_W-1:0]   cfg_wr_data = '0;

    // Shadow of the block's state
    logic [VCNT_W-1:0]   vcount_shadow;
    logic [VIDX_W-1:0]   adj_list [MAX_VERTICES][MAX_DEGREE];
    int                  adj_len  [MAX_VERTICES];
    logic [KEY_W-1:0]    key_shadow [MAX_VERTICES];

    visit_res_t          request_visits [$];   // results of the request just modelled
    visit_res_t          expected_visits [$];  // results still owed by the block

    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  error_count   = 0;
    int                  results_seen  = 0;
    int                  hold_left     = 0;
    bit                  hold_done     = 1'b0;

    // Directed table: reset state, key/index extremes, a list filled by self-loops until
    // it overflows, range errors on vb and key vertices, and vertex_count at 0, 4 and 31.
    stim_row_t directed_rows [26] = '{
        // walks on an empty graph: vertex 0 alone, key 0
        '{1'b0, 5'd0,  REQ_BFS,      4'd0,  4'd0,  8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_DFS,      4'd15, 4'd15, 8'hFF, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_SET_KEY,  4'd0,  4'd15, 8'hFF, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_SET_KEY,  4'd15, 4'd0,  8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_SET_KEY,  4'd7,  4'd9,  8'hA5, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd0,  4'd15, 8'h5A, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd0,  4'd7,  8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        // self-loops on 15: two slots each, 1 -> 15 entries
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        // one slot left: a self-loop will not fit, a plain edge will, then none fits
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_FULL},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd15, 4'd2,  8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd3,  4'd15, 8'h00, 1'b1, 4'd0, 8'h00, STAT_FULL},
        '{1'b0, 5'd0,  REQ_BFS,      4'd0,  4'd0,  8'h00, 1'b0, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_DFS,      4'd0,  4'd0,  8'h00, 1'b0, 4'd0, 8'h00, STAT_OK},
        // count 0 behaves as 1
        '{1'b1, 5'd0,  REQ_SET_KEY,  4'd1,  4'd0,  8'h11, 1'b1, 4'd0, 8'h00, STAT_RANGE},
        '{1'b0, 5'd0,  REQ_ADD_EDGE, 4'd0,  4'd0,  8'h00, 1'b1, 4'd0, 8'h00, STAT_OK},
        '{1'b0, 5'd0,  REQ_BFS,      4'd0,  4'd0,  8'h00, 1'b0, 4'd0, 8'h00, STAT_OK},
        // count lowered to 4: bad second end, bad key vertex, walk skips high entries
        '{1'b1, 5'd4,  REQ_ADD_EDGE, 4'd2,  4'd9,  8'h00, 1'b1, 4'd0, 8'h00, STAT_RANGE},
        '{1'b0, 5'd0,  REQ_SET_KEY,  4'd9,  4'd0,  8'h3C, 1'b1, 4'd0, 8'h00, STAT_RANGE},
        '{1'b0, 5'd0,  REQ_DFS,      4'd0,  4'd0,  8'h00, 1'b0, 4'd0, 8'h00, STAT_OK},
        // count above the maximum behaves as 16
        '{1'b1, 5'd31, REQ_BFS,      4'd0,  4'd0,  8'h00, 1'b0, 4'd0, 8'h00, STAT_OK}
    };

    logic [VCNT_W-1:0] phase_counts [RAND_PHASES] = '{5'd16, 5'd1, 5'd31, 5'd0,
                                                     5'd5, 5'd9, 5'd16, 5'd12};

    graph_bfs_dfs_traversal_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_vertex_a      (s_vertex_a),
        .s_vertex_b      (s_vertex_b),
        .s_key_value     (s_key_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_visited_index (m_visited_index),
        .m_visited_key   (m_visited_key),
        .m_last_flag     (m_last_flag),
        .m_status_code   (m_status_code),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Effective vertex count: 0 reads as 1, anything above the maximum as the maximum
    function automatic int live_vertices();
        if (vcount_shadow == '0) return 1;
        if (int'(vcount_shadow) > MAX_VERTICES) return MAX_VERTICES;
        return int'(vcount_shadow);
    endfunction

    // Apply one request to the shadow state and leave its results in request_visits
    function automatic void predict_request(input req_t rq, input logic [VIDX_W-1:0] va,
                                            input logic [VIDX_W-1:0] vb,
                                            input logic [KEY_W-1:0] kv);
        int          n;
        bit          full;
        int          head;
        int          tail;
        int          cur;
        int          deg;
        int          nb;
        int          i;
        int          order [MAX_VERTICES];
        mark_t       marks [MAX_VERTICES];
        visit_res_t  r;

        n = live_vertices();
        request_visits.delete();
        r = '{vidx: '0, vkey: '0, last: 1'b1, status: STAT_OK};
        case (rq)
            REQ_SET_KEY: begin
                if (int'(va) >= n) r.status = STAT_RANGE;
                else key_shadow[va] = kv;
                request_visits.push_back(r);
            end
            REQ_ADD_EDGE: begin
                if (int'(va) >= n || int'(vb) >= n) begin
                    r.status = STAT_RANGE;
                end else begin
                    // a self-loop takes two slots of the same list
                    if (va == vb) full = adj_len[va] + 2 > MAX_DEGREE;
                    else full = adj_len[va] >= MAX_DEGREE || adj_len[vb] >= MAX_DEGREE;
                    if (full) begin
                        r.status = STAT_FULL;
                    end else begin
                        adj_list[va][adj_len[va]] = vb;
                        adj_len[va]++;
                        adj_list[vb][adj_len[vb]] = va;
                        adj_len[vb]++;
                    end
                end
                request_visits.push_back(r);
            end
            default: begin
                // walk from vertex 0; both walks mark on push; the DFS pops from the tail
                foreach (marks[j]) marks[j] = MARK_NONE;
                marks[0] = MARK_PENDING;
                order[0] = 0;
                head = 0;
                tail = 1;
                while (tail > head) begin
                    if (rq == REQ_DFS) begin
                        tail--;
                        cur = order[tail];
                    end else begin
                        cur = order[head];
                        head++;
                    end
                    request_visits.push_back('{vidx: VIDX_W'(cur), vkey: key_shadow[cur],
                                               last: 1'b0, status: STAT_OK});
                    deg = adj_len[cur];
                    for (i = 0; i < deg; i++) begin
                        nb = int'(adj_list[cur][i]);
                        if (nb < n && marks[nb] == MARK_NONE && tail < MAX_VERTICES) begin
                            marks[nb] = MARK_PENDING;
                            order[tail] = nb;
                            tail++;
                        end
                    end
                    marks[cur] = MARK_DONE;
                end
                request_visits[request_visits.size()-1].last = 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Offer one request, holding it until the transfer, then book its results.
    // s_valid is only lowered when a gap follows, so it never takes two updates in one step.
    task automatic offer_request(input req_t rq, input logic [VIDX_W-1:0] va,
                                 input logic [VIDX_W-1:0] vb, input logic [KEY_W-1:0] kv,
                                 input bit typed, input visit_res_t typed_res);
        int gap;

        gap = 0;
        while (gap < GAP_CAP && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= rq;
        s_vertex_a  <= va;
        s_vertex_b  <= vb;
        s_key_value <= kv;
        do @(posedge aclk); while (!s_ready);
        predict_request(rq, va, vb, kv);
        if (typed) expected_visits.push_back(typed_res);
        else foreach (request_visits[j]) expected_visits.push_back(request_visits[j]);
    endtask

    // Stop offering and wait for every owed result, then give the controller time to
    // return to idle
    task automatic settle_idle();
        int guard;

        guard = 0;
        s_valid <= 1'b0;
        while (expected_visits.size() > 0 && guard < SETTLE_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input logic [VCNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        vcount_shadow = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: check each transfer against the oldest expectation, then choose
    // the next m_ready. Once HOLD_AFTER results are in, m_ready drops for HOLD_CYCLES
    // so the output register fills and s_ready stays low while the next request waits.
    always @(posedge aclk) begin : result_side
        visit_res_t want;

        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_visits.size() == 0) begin
                report_mismatch("unexpected result, visited_index", int'(m_visited_index), -1);
            end else begin
                want = expected_visits.pop_front();
                if (m_visited_index !== want.vidx)
                    report_mismatch("visited_index", int'(m_visited_index), int'(want.vidx));
                if (m_visited_key !== want.vkey)
                    report_mismatch("visited_key", int'(m_visited_key), int'(want.vkey));
                if (m_last_flag !== want.last)
                    report_mismatch("last_flag", int'(m_last_flag), int'(want.last));
                if (m_status_code !== want.status)
                    report_mismatch("status_code", int'(m_status_code), int'(want.status));
            end
        end
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus
    initial begin : stimulus
        visit_res_t         typed_res;
        req_t               rq;
        logic [VIDX_W-1:0]  va;
        logic [VIDX_W-1:0]  vb;
        logic [KEY_W-1:0]   kv;
        int                 n;
        int                 pick;

        vcount_shadow = VCOUNT_RESET;
        foreach (adj_len[j]) adj_len[j] = 0;
        foreach (key_shadow[j]) key_shadow[j] = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, with the sender lightly idle and the receiver heavily so
        send_idle_pct = 22;
        recv_idle_pct = 52;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].cfg) begin
                settle_idle();
                write_vertex_count(directed_rows[r].cfg_val);
            end
            typed_res = '{vidx: directed_rows[r].t_idx, vkey: directed_rows[r].t_key,
                          last: 1'b1, status: directed_rows[r].t_stat};
            offer_request(directed_rows[r].rq, directed_rows[r].va, directed_rows[r].vb,
                          directed_rows[r].kv, directed_rows[r].typed, typed_res);
        end

        // Random phases: each starts from a drained block with a fresh vertex_count.
        // Idle pattern: sender 22 / receiver 52, then swapped, then no idling.
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle_idle();
            if (p < 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 52;
            end else if (p < 6) begin
                send_idle_pct = 52;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_vertex_count(phase_counts[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                n    = live_vertices();
                pick = $urandom_range(0, 99);
                va   = VIDX_W'($urandom_range(0, 15));
                vb   = VIDX_W'($urandom_range(0, 15));
                kv   = KEY_W'($urandom_range(0, 255));
                if (pick < 8) begin
                    // noise: any request, indices anywhere in the field
                    rq = req_t'($urandom_range(0, 3));
                end else if (pick < 50) begin
                    rq = REQ_ADD_EDGE;
                    va = VIDX_W'($urandom_range(0, n - 1));
                    vb = VIDX_W'($urandom_range(0, n - 1));
                end else if (pick < 72) begin
                    rq = REQ_SET_KEY;
                    va = VIDX_W'($urandom_range(0, n - 1));
                end else begin
                    rq = $urandom_range(0, 1) ? REQ_DFS : REQ_BFS;
                end
                offer_request(rq, va, vb, kv, 1'b0, typed_res);
            end
        end

        // Drain and finish
        settle_idle();
        repeat (20) @(posedge aclk);
        if (expected_visits.size() > 0)
            report_mismatch("results never delivered", 0, expected_visits.size());
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
